### sv/cfdzc_pkg.sv
`timescale 1ns / 1ps
// package for the cfd zero-crossing phase block
// shared constants, status and register codes, config and divider structs; no dependencies

package cfdzc_pkg;

    localparam int CFDZC_MAX_DELAY   = 64;
    localparam int CFDZC_MAX_WINDOW  = 4096;
    localparam int CFDZC_SAMPLE_BITS = 16;

    localparam int MEAN_W     = 20;
    localparam int SIGMA_W    = 20;
    localparam int STATUS_W   = 2;
    localparam int PHASE_W    = 20;
    localparam int PHASE_FRAC = 8;
    localparam int PHASE_MAX  = (1 << PHASE_W) - 1;
    localparam int LIMIT_W    = 40;
    localparam int LIMIT_SHIFT = 3;
    localparam int FRAC_SHIFT = 15;

    localparam int DELAY_W    = 6;
    localparam int FRAC_W     = 16;
    localparam int THRESH_W   = 16;
    localparam int WINDOW_W   = 13;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 4;

    localparam logic [DELAY_W-1:0]  DELAY_RESET     = 6'd4;
    localparam logic [FRAC_W-1:0]   FRACTION_RESET  = 16'd16384;
    localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 16'd0;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET    = 13'd4096;

    localparam logic [STATUS_W-1:0] ST_FOUND   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADBASE = 2'd2;

    localparam logic [1:0] REG_DELAY     = 2'd0;
    localparam logic [1:0] REG_FRACTION  = 2'd1;
    localparam logic [1:0] REG_THRESHOLD = 2'd2;
    localparam logic [1:0] REG_WINDOW    = 2'd3;

    typedef struct packed {
        logic [DELAY_W-1:0]  delay;
        logic [FRAC_W-1:0]   fraction;
        logic [THRESH_W-1:0] threshold;
        logic [WINDOW_W-1:0] window;
    } cfg_t;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic done;
        logic rem_nz;
    } div_stat_t;

endpackage

### sv/cfdzc_in_if.sv
`timescale 1ns / 1ps
// sample channel: valid/ready handshake carrying one trace sample per transaction
// depends on cfdzc_pkg

interface cfdzc_in_if import cfdzc_pkg::*; #(
    parameter int SAMPLE_BITS = CFDZC_SAMPLE_BITS
) ();
    logic                      valid;
    logic                      ready;
    logic [SAMPLE_BITS-1:0]    sample;
    logic signed [MEAN_W-1:0]  baseline_mean;
    logic [SIGMA_W-1:0]        baseline_sigma;
    logic                      last;

    modport source (
        output valid,
        output sample,
        output baseline_mean,
        output baseline_sigma,
        output last,
        input  ready
    );

    modport sink (
        input  valid,
        input  sample,
        input  baseline_mean,
        input  baseline_sigma,
        input  last,
        output ready
    );
endinterface

### sv/cfdzc_out_if.sv
`timescale 1ns / 1ps
// result channel: valid/ready handshake carrying status and phase per transaction
// depends on cfdzc_pkg

interface cfdzc_out_if import cfdzc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [PHASE_W-1:0]  phase;

    modport source (
        output valid,
        output status,
        output phase,
        input  ready
    );

    modport sink (
        input  valid,
        input  status,
        input  phase,
        output ready
    );
endinterface

### sv/cfd_zero_crossing_phase_core.sv
`timescale 1ns / 1ps
// top level: apb configuration registers around the cfd zero-crossing core
// depends on cfdzc_pkg, cfdzc_in_if, cfdzc_out_if, cfdzc_core

// Digital constant fraction discriminator. Samples of a trace come in one per
// transaction on the trace channel; the sample with last set closes the trace
// and produces exactly one transaction on the result channel: the interpolated
// zero-crossing position in Q12.8 samples, no crossing, or bad baseline. After
// a sample is accepted, ready stays low while the sequencer steps one shared
// multiplier and the delay-line ram through read, multiply, subtract and
// update. The last sample of a trace adds a closing step, followed, when a
// crossing was found at window index 2 or later and the baseline is good, by
// the bit-serial phase divider. The closing step also waits while a previous
// result has not been taken. Registers at byte addresses 0, 4, 8, 12:
// cfd_delay, cfd_fraction (Q1.15), threshold_factor (Q4.12), window_length.

module cfd_zero_crossing_phase_core import cfdzc_pkg::*; #(
    parameter int MAX_DELAY   = CFDZC_MAX_DELAY,
    parameter int MAX_WINDOW  = CFDZC_MAX_WINDOW,
    parameter int SAMPLE_BITS = CFDZC_SAMPLE_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    cfdzc_in_if.sink              trace,
    cfdzc_out_if.source           result
);

    logic [DELAY_W-1:0]  delay_reg;
    logic [FRAC_W-1:0]   fraction_reg;
    logic [THRESH_W-1:0] threshold_reg;
    logic [WINDOW_W-1:0] window_reg;
    logic [1:0]          cfg_sel;
    logic                cfg_write;
    cfg_t                cfg;

    assign pready    = 1'b1;
    assign cfg_sel   = paddr[CFG_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg     <= DELAY_RESET;
            fraction_reg  <= FRACTION_RESET;
            threshold_reg <= THRESHOLD_RESET;
            window_reg    <= WINDOW_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                REG_DELAY:     delay_reg     <= pwdata[DELAY_W-1:0];
                REG_FRACTION:  fraction_reg  <= pwdata[FRAC_W-1:0];
                REG_THRESHOLD: threshold_reg <= pwdata[THRESH_W-1:0];
                REG_WINDOW:    window_reg    <= pwdata[WINDOW_W-1:0];
                default:       delay_reg     <= delay_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            REG_DELAY:     prdata = CFG_DATA_W'(delay_reg);
            REG_FRACTION:  prdata = CFG_DATA_W'(fraction_reg);
            REG_THRESHOLD: prdata = CFG_DATA_W'(threshold_reg);
            REG_WINDOW:    prdata = CFG_DATA_W'(window_reg);
            default:       prdata = '0;
        endcase
    end

    assign cfg.delay     = delay_reg;
    assign cfg.fraction  = fraction_reg;
    assign cfg.threshold = threshold_reg;
    assign cfg.window    = window_reg;

    cfdzc_core #(
        .MAX_DELAY   (MAX_DELAY),
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .trace  (trace),
        .result (result)
    );

`ifndef SYNTHESIS
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.status == ST_FOUND || result.status == ST_NONE
                          || result.status == ST_BADBASE))
        else $error("result status outside the defined codes");

    a_phase_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status != ST_FOUND) |-> (result.phase == '0))
        else $error("phase nonzero without a found crossing");

    a_one_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (trace.valid && trace.ready) |=> !trace.ready)
        else $error("sample accepted while previous transaction still in work");
`endif

endmodule

### sv/cfdzc_ram.sv
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies

module cfdzc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

### sv/cfdzc_div.sv
`timescale 1ns / 1ps
// bit-serial restoring divider, one quotient bit per cycle
// depends on cfdzc_pkg for the control and status structs

module cfdzc_div import cfdzc_pkg::*; #(
    parameter int NW = CFDZC_SAMPLE_BITS + 26,
    parameter int DW = CFDZC_SAMPLE_BITS + 18
) (
    input  logic          clk,
    input  logic          rst_n,
    input  div_ctrl_t     ctrl,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output div_stat_t     stat,
    output logic [NW-1:0] quot
);

    localparam int CNTW = $clog2(NW + 1);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0]   qr_reg;
    logic [DW-1:0]   rem_reg;
    logic [DW-1:0]   den_reg;

    logic [DW:0]     trial;
    logic [DW:0]     diff;
    logic            fits;
    logic [DW-1:0]   rem_step;

    always_comb
    begin
        trial    = {rem_reg, qr_reg[NW-1]};
        diff     = trial - {1'b0, den_reg};
        fits     = trial >= {1'b0, den_reg};
        rem_step = fits ? diff[DW-1:0] : trial[DW-1:0];
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = CNTW'(NW);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNTW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            qr_reg  <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            qr_reg  <= {qr_reg[NW-2:0], fits};
            rem_reg <= rem_step;
        end
    end

    assign quot        = qr_reg;
    assign stat.done   = done_reg;
    assign stat.rem_nz = rem_reg != '0;

endmodule

### sv/cfdzc_core.sv
`timescale 1ns / 1ps
// sequencer and datapath: shared multiplier, delay-line ram, arming and crossing search
// depends on cfdzc_pkg, cfdzc_in_if, cfdzc_out_if, cfdzc_ram, cfdzc_div

module cfdzc_core import cfdzc_pkg::*; #(
    parameter int MAX_DELAY   = CFDZC_MAX_DELAY,
    parameter int MAX_WINDOW  = CFDZC_MAX_WINDOW,
    parameter int SAMPLE_BITS = CFDZC_SAMPLE_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    cfdzc_in_if.sink     trace,
    cfdzc_out_if.source  result
);

    localparam int DLW         = $clog2(MAX_DELAY);
    localparam int IW          = $clog2(MAX_WINDOW);
    localparam int WLW         = $clog2(MAX_WINDOW + 1);
    localparam int COUNT_LIMIT = MAX_WINDOW + MAX_DELAY;
    localparam int PCW         = $clog2(COUNT_LIMIT + 1);
    localparam int CW          = SAMPLE_BITS + 18;
    localparam int MA          = FRAC_W + 1;
    localparam int MB          = (SAMPLE_BITS + 1 > SIGMA_W + 1) ? SAMPLE_BITS + 1 : SIGMA_W + 1;
    localparam int PW          = MA + MB;
    localparam int CMPW        = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam int NW          = CW + PHASE_FRAC;
    localparam int QW          = NW + 1;
    localparam int SW          = NW + 2;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_READ = 4'd1;
    localparam logic [3:0] S_MUL  = 4'd2;
    localparam logic [3:0] S_CFD  = 4'd3;
    localparam logic [3:0] S_UPD  = 4'd4;
    localparam logic [3:0] S_FIN  = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_FIX  = 4'd7;
    localparam logic [3:0] S_SUM  = 4'd8;

    logic [3:0]                state_reg, state_next;
    logic [PCW-1:0]            pc_reg, pc_next;
    logic [DLW-1:0]            wptr_reg, wptr_next;
    logic                      armed_reg, armed_next;
    logic                      found_reg, found_next;
    logic [IW-1:0]             cidx_reg, cidx_next;
    logic signed [CW-1:0]      prev_reg, prev_next;
    logic signed [CW-1:0]      low_reg, low_next;
    logic signed [CW-1:0]      high_reg, high_next;
    logic signed [LIMIT_W-1:0] limit_reg, limit_next;
    logic                      bad_reg, bad_next;
    logic                      out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]       status_reg, status_next;
    logic [PHASE_W-1:0]        phase_reg, phase_next;

    logic [SAMPLE_BITS-1:0]    x_reg;
    logic [SIGMA_W-1:0]        sigma_reg;
    logic                      last_reg;
    logic                      first_reg;
    logic                      eval_reg;
    logic                      active_reg;
    logic                      use_x_reg;
    logic [IW-1:0]             pidx_reg;
    logic [DLW-1:0]            rdaddr_reg;
    logic signed [PW-1:0]      prod_reg;
    logic [SAMPLE_BITS-1:0]    xp_reg;
    logic signed [CW-1:0]      c_reg;
    logic                      neg_reg;
    logic [IW-1:0]             base_reg;
    logic signed [QW-1:0]      q_reg;

    logic                      accept;
    logic [DLW-1:0]            d_cl;
    logic [WLW-1:0]            win_cl;
    logic                      active;
    logic [PCW-1:0]            p;
    logic                      eval;
    logic [DLW:0]              rd_tmp;
    logic [DLW:0]              rd_wrap;
    logic [DLW-1:0]            rd_addr;

    logic signed [MA-1:0]      mult_a;
    logic signed [MB-1:0]      mult_b;
    logic signed [PW-1:0]      prod_full;
    logic signed [CW-1:0]      c_full;
    logic                      c_lt;
    logic                      c_pos;
    logic                      low_pos;
    logic [CW-1:0]             abs_low;
    logic signed [CW:0]        den_wide;
    logic signed [QW-1:0]      quot_s;
    logic signed [QW-1:0]      q_full;
    logic signed [SW-1:0]      sum;
    logic [PHASE_W-1:0]        phase_sat;

    logic [SAMPLE_BITS-1:0]    ram_rdata;
    logic                      ram_we;
    div_ctrl_t                 div_ctrl;
    div_stat_t                 div_stat;
    logic [NW-1:0]             div_num;
    logic [CW-1:0]             div_den;
    logic [NW-1:0]             div_quot;

    assign trace.ready   = state_reg == S_IDLE;
    assign accept        = trace.valid && (state_reg == S_IDLE);
    assign result.valid  = out_valid_reg;
    assign result.status = status_reg;
    assign result.phase  = phase_reg;

    // position bookkeeping for the incoming sample
    always_comb
    begin
        if (32'(cfg.delay) > 32'(MAX_DELAY - 1))
        begin
            d_cl = DLW'(MAX_DELAY - 1);
        end
        else
        begin
            d_cl = DLW'(cfg.delay);
        end
        if (32'(cfg.window) > 32'(MAX_WINDOW))
        begin
            win_cl = WLW'(MAX_WINDOW);
        end
        else
        begin
            win_cl = WLW'(cfg.window);
        end
        active  = pc_reg < PCW'(COUNT_LIMIT);
        p       = pc_reg - PCW'(d_cl);
        eval    = active && (pc_reg >= PCW'(d_cl)) && !found_reg
                  && (32'(p) < 32'(win_cl));
        rd_tmp  = {1'b0, wptr_reg} - {1'b0, d_cl};
        rd_wrap = rd_tmp + (DLW + 1)'(MAX_DELAY);
        rd_addr = rd_tmp[DLW] ? rd_wrap[DLW-1:0] : rd_tmp[DLW-1:0];
    end

    // shared multiplier: arming limit first, then fraction times sample
    always_comb
    begin
        if (state_reg == S_READ)
        begin
            mult_a = $signed({cfg.threshold[THRESH_W-1], cfg.threshold});
            mult_b = $signed(MB'(sigma_reg));
        end
        else
        begin
            mult_a = $signed({1'b0, cfg.fraction});
            mult_b = $signed(MB'(x_reg));
        end
        prod_full = mult_a * mult_b;
    end

    always_comb
    begin
        c_full   = ($signed(CW'(xp_reg)) <<< FRAC_SHIFT) - CW'(prod_reg);
        c_lt     = CMPW'(c_reg) < CMPW'(limit_reg);
        c_pos    = !c_reg[CW-1] && (c_reg != '0);
        low_pos  = !low_reg[CW-1] && (low_reg != '0);
        abs_low  = low_reg[CW-1] ? CW'(-low_reg) : CW'(low_reg);
        den_wide = (CW + 1)'(high_reg) - (CW + 1)'(low_reg);
        div_num  = {abs_low, PHASE_FRAC'(0)};
        div_den  = den_wide[CW-1:0];
        quot_s   = $signed({1'b0, div_quot});
        q_full   = neg_reg ? (-quot_s - $signed(QW'(div_stat.rem_nz))) : quot_s;
        sum      = $signed(SW'({base_reg, PHASE_FRAC'(0)})) + SW'(q_reg);
        if (sum[SW-1])
        begin
            phase_sat = '0;
        end
        else if (sum > SW'(PHASE_MAX))
        begin
            phase_sat = PHASE_W'(PHASE_MAX);
        end
        else
        begin
            phase_sat = sum[PHASE_W-1:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        wptr_next      = wptr_reg;
        armed_next     = armed_reg;
        found_next     = found_reg;
        cidx_next      = cidx_reg;
        prev_next      = prev_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        limit_next     = limit_reg;
        bad_next       = bad_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        phase_next     = phase_reg;
        div_ctrl.start = 1'b0;
        ram_we         = 1'b0;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (trace.valid)
                begin
                    state_next = S_READ;
                    if (pc_reg == '0)
                    begin
                        bad_next = trace.baseline_mean[MEAN_W-1];
                    end
                end
            end
            S_READ:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (first_reg)
                begin
                    limit_next = LIMIT_W'(prod_reg) <<< LIMIT_SHIFT;
                end
                state_next = S_CFD;
            end
            S_CFD:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (eval_reg)
                begin
                    if (c_lt)
                    begin
                        armed_next = 1'b1;
                    end
                    else if (armed_reg && c_pos)
                    begin
                        found_next = 1'b1;
                        cidx_next  = pidx_reg;
                        low_next   = prev_reg;
                        high_next  = c_reg;
                    end
                    prev_next = c_reg;
                end
                if (active_reg)
                begin
                    ram_we  = 1'b1;
                    pc_next = pc_reg + 1'b1;
                    if (wptr_reg == DLW'(MAX_DELAY - 1))
                    begin
                        wptr_next = '0;
                    end
                    else
                    begin
                        wptr_next = wptr_reg + 1'b1;
                    end
                end
                state_next = last_reg ? S_FIN : S_IDLE;
            end
            S_FIN:
            begin
                if (!out_valid_reg)
                begin
                    if (bad_reg)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = ST_BADBASE;
                        phase_next     = '0;
                        state_next     = S_IDLE;
                    end
                    else if (found_reg && (cidx_reg >= IW'(2)))
                    begin
                        div_ctrl.start = 1'b1;
                        state_next     = S_DIV;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        status_next    = ST_NONE;
                        phase_next     = '0;
                        state_next     = S_IDLE;
                    end
                    // end of trace
                    pc_next    = '0;
                    wptr_next  = '0;
                    armed_next = 1'b0;
                    found_next = 1'b0;
                    cidx_next  = '0;
                    prev_next  = '0;
                    low_next   = '0;
                    high_next  = '0;
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = S_FIX;
                end
            end
            S_FIX:
            begin
                state_next = S_SUM;
            end
            S_SUM:
            begin
                out_valid_next = 1'b1;
                status_next    = ST_FOUND;
                phase_next     = phase_sat;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= '0;
            wptr_reg      <= '0;
            armed_reg     <= 1'b0;
            found_reg     <= 1'b0;
            cidx_reg      <= '0;
            prev_reg      <= '0;
            low_reg       <= '0;
            high_reg      <= '0;
            limit_reg     <= '0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_FOUND;
            phase_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            wptr_reg      <= wptr_next;
            armed_reg     <= armed_next;
            found_reg     <= found_next;
            cidx_reg      <= cidx_next;
            prev_reg      <= prev_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
            limit_reg     <= limit_next;
            bad_reg       <= bad_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg      <= trace.sample;
            last_reg   <= trace.last;
            first_reg  <= pc_reg == '0;
            eval_reg   <= eval;
            active_reg <= active;
            use_x_reg  <= d_cl == '0;
            pidx_reg   <= IW'(p);
            rdaddr_reg <= rd_addr;
            if (pc_reg == '0)
            begin
                sigma_reg <= trace.baseline_sigma;
            end
        end
        if ((state_reg == S_READ) || (state_reg == S_MUL))
        begin
            prod_reg <= prod_full;
        end
        if (state_reg == S_MUL)
        begin
            xp_reg <= use_x_reg ? x_reg : ram_rdata;
        end
        if (state_reg == S_CFD)
        begin
            c_reg <= c_full;
        end
        if (div_ctrl.start)
        begin
            neg_reg  <= low_pos;
            base_reg <= cidx_reg - IW'(1);
        end
        if (state_reg == S_FIX)
        begin
            q_reg <= q_full;
        end
    end

    cfdzc_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_DELAY)
    ) u_delay_line (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wptr_reg),
        .wdata (x_reg),
        .raddr (rdaddr_reg),
        .rdata (ram_rdata)
    );

    cfdzc_div #(
        .NW (NW),
        .DW (CW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .num   (div_num),
        .den   (div_den),
        .stat  (div_stat),
        .quot  (div_quot)
    );

endmodule
